// ===== rtl/srec_pkg.sv =====
package srec_pkg;

	localparam int RECORD_BYTES = 16;
	localparam int BIDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int CNT_W = $clog2(RECORD_BYTES + 1);
	localparam int IDX_W = (BIDX_W > 2) ? BIDX_W : 2;

	localparam logic [1:0] FUNC_DATA    = 2'd0;
	localparam logic [1:0] FUNC_FLUSH   = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	localparam logic CFG_RECORD_TYPE   = 1'b0;
	localparam logic CFG_START_ADDRESS = 1'b1;

	localparam logic [7:0] CHAR_S  = 8'h53;
	localparam logic [7:0] CHAR_NL = 8'h0A;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic [7:0]       sum;
		logic [31:0]      addr;
		logic [3:0]       rtype;
	} rec_cmd_t;

	typedef struct packed {
		logic              bank;
		logic [BIDX_W-1:0] idx;
	} buf_rd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		case (nib)
			4'h0: c = 8'h30;
			4'h1: c = 8'h31;
			4'h2: c = 8'h32;
			4'h3: c = 8'h33;
			4'h4: c = 8'h34;
			4'h5: c = 8'h35;
			4'h6: c = 8'h36;
			4'h7: c = 8'h37;
			4'h8: c = 8'h38;
			4'h9: c = 8'h39;
			4'hA: c = 8'h41;
			4'hB: c = 8'h42;
			4'hC: c = 8'h43;
			4'hD: c = 8'h44;
			4'hE: c = 8'h45;
			default: c = 8'h46;
		endcase
		return c;
	endfunction

	// address bytes carried by a record of the given type
	function automatic logic [2:0] addr_bytes(input logic [3:0] rtype);
		logic [2:0] n;
		case (rtype)
			4'd0, 4'd1, 4'd9: n = 3'd2;
			4'd2, 4'd8:       n = 3'd3;
			4'd3, 4'd7:       n = 3'd4;
			default:          n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/srec_front.sv =====
module srec_front
	import srec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        push,
	output rec_cmd_t    push_cmd,
	input  logic        rec_done,
	input  buf_rd_t     buf_rd,
	output logic [7:0]  buf_data
);

	logic [CNT_W-1:0] fill_q;
	logic [7:0]       sum_q;
	logic [31:0]      addr_q;
	logic             bank_q;
	logic [1:0]       outst_q;
	logic [3:0]       rtype_q;
	logic [31:0]      saddr_q;
	logic [7:0]       bank_a_q [RECORD_BYTES];
	logic [7:0]       bank_b_q [RECORD_BYTES];

	logic             accept;
	logic             is_data;
	logic [CNT_W-1:0] fill_inc;
	logic [7:0]       sum_add;

	// both banks owned by pending records: hold the input
	assign in_stall = (outst_q == 2'd2);
	assign accept   = in_valid && !in_stall;
	assign is_data  = (func == FUNC_DATA);
	assign fill_inc = fill_q + CNT_W'(1);
	assign sum_add  = sum_q + data_byte;

	assign push = accept && ((is_data && fill_q == CNT_W'(RECORD_BYTES - 1))
		|| func == FUNC_FLUSH);

	always_comb begin
		push_cmd.bank  = bank_q;
		push_cmd.count = is_data ? fill_inc : fill_q;
		push_cmd.sum   = is_data ? sum_add : sum_q;
		push_cmd.addr  = addr_q;
		push_cmd.rtype = rtype_q;
	end

	assign buf_data = buf_rd.bank ? bank_b_q[buf_rd.idx] : bank_a_q[buf_rd.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			sum_q   <= '0;
			addr_q  <= '0;
			bank_q  <= 1'b0;
			outst_q <= '0;
			rtype_q <= '0;
			saddr_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_RECORD_TYPE)
					rtype_q <= cfg_data[3:0];
				else
					saddr_q <= cfg_data;
			end
			outst_q <= outst_q + {1'b0, push} - {1'b0, rec_done};
			if (push) begin
				fill_q <= '0;
				sum_q  <= '0;
				addr_q <= addr_q + 32'(push_cmd.count);
				bank_q <= !bank_q;
			end else if (accept && is_data) begin
				fill_q <= fill_inc;
				sum_q  <= sum_add;
			end else if (accept && func == FUNC_RESTART) begin
				fill_q <= '0;
				sum_q  <= '0;
				addr_q <= saddr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_data) begin
			if (bank_q)
				bank_b_q[fill_q[BIDX_W-1:0]] <= data_byte;
			else
				bank_a_q[fill_q[BIDX_W-1:0]] <= data_byte;
		end
	end

endmodule

// ===== rtl/srec_cmdq.sv =====
module srec_cmdq
	import srec_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  rec_cmd_t wr_cmd,
	input  logic     rd_en,
	output rec_cmd_t rd_cmd,
	output logic     not_empty
);

	rec_cmd_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;

	assign rd_cmd    = slot_q[rd_ptr_q];
	assign not_empty = (level_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= !rd_ptr_q;
			level_q <= level_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

// ===== rtl/srec_back.sv =====
module srec_back
	import srec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  rec_cmd_t   q_cmd,
	output logic       q_pop,
	output buf_rd_t    buf_rd,
	input  logic [7:0] buf_data,
	output logic       rec_done,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_char
);

	localparam logic [2:0] PH_S    = 3'd0;
	localparam logic [2:0] PH_TYPE = 3'd1;
	localparam logic [2:0] PH_CNT  = 3'd2;
	localparam logic [2:0] PH_ADDR = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_SUM  = 3'd5;
	localparam logic [2:0] PH_NL   = 3'd6;

	rec_cmd_t         cmd_q;
	logic             busy_q;
	logic [2:0]       phase_q;
	logic             lo_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       csum_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             last_q;

	logic             slot_free;
	logic             emit;
	logic [2:0]       ab;
	logic [7:0]       cur_byte;
	logic [7:0]       addr_byte;
	logic [1:0]       addr_pos;
	logic [7:0]       next_char;
	logic             has_data;
	logic             addr_end;
	logic             data_end;

	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = busy_q && slot_free;
	assign q_pop     = !busy_q && q_not_empty;
	assign ab        = addr_bytes(cmd_q.rtype);
	assign has_data  = (cmd_q.count != '0);
	assign addr_end  = ({1'b0, idx_q[1:0]} == ab - 3'd1);
	assign data_end  = ((CNT_W + 1)'(idx_q) + (CNT_W + 1)'(1) == {1'b0, cmd_q.count});
	assign addr_pos  = 2'(ab - 3'd1 - {1'b0, idx_q[1:0]});

	assign buf_rd.bank = cmd_q.bank;
	assign buf_rd.idx  = idx_q[BIDX_W-1:0];

	always_comb begin
		case (addr_pos)
			2'd0:    addr_byte = cmd_q.addr[7:0];
			2'd1:    addr_byte = cmd_q.addr[15:8];
			2'd2:    addr_byte = cmd_q.addr[23:16];
			default: addr_byte = cmd_q.addr[31:24];
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_CNT:  cur_byte = 8'(ab) + 8'd1 + 8'(cmd_q.count);
			PH_ADDR: cur_byte = addr_byte;
			PH_DATA: cur_byte = buf_data;
			default: cur_byte = ~csum_q;
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_S:    next_char = CHAR_S;
			PH_TYPE: next_char = hex_char(cmd_q.rtype);
			PH_NL:   next_char = CHAR_NL;
			default: next_char = hex_char(lo_q ? cur_byte[3:0] : cur_byte[7:4]);
		endcase
	end

	assign rec_done = emit && (phase_q == PH_NL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_S;
			lo_q        <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free)
				out_valid_q <= emit;
			if (q_pop) begin
				busy_q  <= 1'b1;
				phase_q <= PH_S;
				lo_q    <= 1'b0;
				idx_q   <= '0;
			end else if (emit) begin
				case (phase_q)
					PH_S: phase_q <= PH_TYPE;
					PH_TYPE: begin
						if (ab != 3'd0)
							phase_q <= PH_CNT;
						else if (has_data)
							phase_q <= PH_DATA;
						else
							phase_q <= PH_SUM;
					end
					PH_CNT: begin
						lo_q <= !lo_q;
						if (lo_q)
							phase_q <= PH_ADDR;
					end
					PH_ADDR: begin
						lo_q <= !lo_q;
						if (lo_q) begin
							if (addr_end) begin
								idx_q   <= '0;
								phase_q <= has_data ? PH_DATA : PH_SUM;
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
						end
					end
					PH_DATA: begin
						lo_q <= !lo_q;
						if (lo_q) begin
							if (data_end)
								phase_q <= PH_SUM;
							else
								idx_q <= idx_q + IDX_W'(1);
						end
					end
					PH_SUM: begin
						lo_q <= !lo_q;
						if (lo_q)
							phase_q <= PH_NL;
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q  <= q_cmd;
			csum_q <= q_cmd.sum;
		end else if (emit && lo_q && (phase_q == PH_CNT || phase_q == PH_ADDR)) begin
			// fold count and address bytes into the checksum as they go out
			csum_q <= csum_q + cur_byte;
		end
		if (slot_free) begin
			out_char_q <= next_char;
			last_q     <= (phase_q == PH_NL);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule

// ===== rtl/srecord_emitter_top.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   func[1:0], data_byte[7:0]
// out      output     out_valid / out_stall out_char[7:0], last_char
// cfg      input      cfg_we                cfg_index, cfg_data[31:0]
//
// The front takes unstalled input items into one of two byte banks.
// A record is loaded into the back sequencer, which sends it as 5 + 2*N
// characters, and 2 + 2*A more when the type carries a count and address
// (A address bytes, N data bytes); out_stall holds the output.
// The input stalls only while both banks belong to records not yet sent.
// arst_n clears counters, sum, address, configuration and the queue.
module srecord_emitter_top
	import srec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last_char,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic       push;
	rec_cmd_t   push_cmd;
	logic       q_pop;
	rec_cmd_t   q_cmd;
	logic       q_not_empty;
	logic       rec_done;
	buf_rd_t    buf_rd;
	logic [7:0] buf_data;

	srec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_byte (data_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_cmd  (push_cmd),
		.rec_done  (rec_done),
		.buf_rd    (buf_rd),
		.buf_data  (buf_data)
	);

	srec_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_cmd    (push_cmd),
		.rd_en     (q_pop),
		.rd_cmd    (q_cmd),
		.not_empty (q_not_empty)
	);

	srec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.buf_rd      (buf_rd),
		.buf_data    (buf_data),
		.rec_done    (rec_done),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_char   (last_char)
	);

endmodule
